FILE: rtl/lfss_pkg.sv
// Shared types and constants of the LED fade and sleep sequencer.
`default_nettype none

package lfss_pkg;

  // Timing constants, in timer ticks.
  localparam logic [31:0] WAKE_DELAY        = 32'd31;
  localparam logic [31:0] DIMMED_WAKE_EXTRA = 32'd2003;
  localparam logic [31:0] STEP_DELAY        = 32'd7;
  localparam logic [31:0] HOLD_DELAY        = 32'd8009;
  localparam logic [31:0] DIM_STEP_EXTRA    = 32'd12;
  localparam logic [31:0] FAR_DELAY         = 32'h7FFF_FFFE;
  localparam logic [31:0] EXPIRE_LIMIT      = 32'h7FFF_FFFF;

  // Reset values of the configuration registers that are not zero.
  localparam logic [31:0] OFF_WAIT_RESET    = 32'd30011;
  localparam logic [7:0]  DIM_FLOOR_RESET   = 8'd31;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_HUE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_SAT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_VAL   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_SPEED = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_MODE  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_ON    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_OFF_WAIT     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_DIM_FLOOR    = 3'd7;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_WAKE = 2'd1,
    ACT_KEY  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // Classified command passed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WAKE,
    CMD_KEY,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic        palette;
    logic [31:0] now_time;
    logic [31:0] wake_time;      // now + wake delay
    logic [31:0] wake_dim_time;  // now + wake delay + dimmed extra
    logic [31:0] far_time;       // now + far delay
  } cmd_t;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic [7:0]  target_hue;
    logic [7:0]  target_sat;
    logic [7:0]  target_val;
    logic [7:0]  target_speed;
    logic [7:0]  target_mode;
    logic        target_on;
    logic [31:0] off_wait_step;  // off wait plus the step delay
    logic [7:0]  dim_floor;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] speed;
    logic [7:0] mode;
    logic       on;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/led_fade_sleep_sequencer.sv
// Top level of the LED fade and sleep sequencer.
//
// Input channel: an input word (action, now_time, palette_held) is taken at a
// rising edge where push is high and full is low. Result channel: while empty
// is low the oldest result word is on the cur_* and lights_on ports, and it is
// taken at a rising edge where pop is high. Every input word gives exactly one
// result word, the lighting state after that word.
// The front end classifies words into a command queue; the back end carries
// out one command per cycle while the result queue has room and writes a
// result queue. A word taken is registered in the command queue, then its
// result in the result queue, and only then is it on the result ports; one
// word per cycle is sustained while the receiver keeps popping.
// When the receiver stops popping, the result queue fills, the back end waits,
// then the command queue fills and full rises; nothing is lost.
// Reset clears both queues and puts the lighting state and registers to their
// reset values. The user writes configuration registers through cfg_we_i,
// cfg_idx_i and cfg_wdata_i only while the block is idle; nothing enforces it.
`default_nettype none

module led_fade_sleep_sequencer #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Input channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] now_time_i,
  input  wire logic        palette_held_i,
  // Result channel
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       cur_hue_o,
  output logic [7:0]       cur_sat_o,
  output logic [7:0]       cur_val_o,
  output logic [7:0]       cur_speed_o,
  output logic [7:0]       cur_mode_o,
  output logic             lights_on_o
);

  import lfss_pkg::*;

  cfg_t cfg_q;
  cmd_t front_cmd, back_cmd;
  res_t back_res, out_res;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic res_push, res_full;

  // Configuration registers. The off wait is kept with the step delay
  // already added, as the back end always needs the sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_hue    <= 8'd0;
      cfg_q.target_sat    <= 8'd0;
      cfg_q.target_val    <= 8'd0;
      cfg_q.target_speed  <= 8'd0;
      cfg_q.target_mode   <= 8'd0;
      cfg_q.target_on     <= 1'b0;
      cfg_q.off_wait_step <= OFF_WAIT_RESET + STEP_DELAY;
      cfg_q.dim_floor     <= DIM_FLOOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_HUE:   cfg_q.target_hue    <= cfg_wdata_i[7:0];
        CFG_TARGET_SAT:   cfg_q.target_sat    <= cfg_wdata_i[7:0];
        CFG_TARGET_VAL:   cfg_q.target_val    <= cfg_wdata_i[7:0];
        CFG_TARGET_SPEED: cfg_q.target_speed  <= cfg_wdata_i[7:0];
        CFG_TARGET_MODE:  cfg_q.target_mode   <= cfg_wdata_i[7:0];
        CFG_TARGET_ON:    cfg_q.target_on     <= cfg_wdata_i[0];
        CFG_OFF_WAIT:     cfg_q.off_wait_step <= cfg_wdata_i + STEP_DELAY;
        CFG_DIM_FLOOR:    cfg_q.dim_floor     <= cfg_wdata_i[7:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Front end: classify and queue.
  lfss_front u_front (
    .push_i         (push),
    .action_i       (action_i),
    .now_time_i     (now_time_i),
    .palette_held_i (palette_held_i),
    .q_full_i       (cmd_full),
    .q_push_o       (cmd_push),
    .cmd_o          (front_cmd)
  );

  assign full = cmd_full;

  // Command queue between front and back end.
  lfss_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  // Back end: state update.
  lfss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // Result queue towards the receiver.
  lfss_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign cur_hue_o   = out_res.hue;
  assign cur_sat_o   = out_res.sat;
  assign cur_val_o   = out_res.val;
  assign cur_speed_o = out_res.speed;
  assign cur_mode_o  = out_res.mode;
  assign lights_on_o = out_res.on;

endmodule

`default_nettype wire

FILE: rtl/lfss_fifo.sv
// Small register queue used between the front end, back end and result port.
`default_nettype none

module lfss_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic [WIDTH-1:0]  mem_q [DEPTH];
  logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset: only written entries are ever read.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lfss_front.sv
// Front end: accepts input words, classifies the action and prepares deadlines.
`default_nettype none

module lfss_front (
  input  wire logic          push_i,
  input  wire logic [1:0]    action_i,
  input  wire logic [31:0]   now_time_i,
  input  wire logic          palette_held_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output lfss_pkg::cmd_t     cmd_o
);

  import lfss_pkg::*;

  action_e act;

  assign act      = action_e'(action_i);
  assign q_push_o = push_i && !q_full_i;

  // Decode the action and work out the candidate deadlines ahead of time,
  // so that the back end only has to pick one.
  always_comb begin
    cmd_o.palette       = palette_held_i;
    cmd_o.now_time      = now_time_i;
    cmd_o.wake_time     = now_time_i + WAKE_DELAY;
    cmd_o.wake_dim_time = now_time_i + (WAKE_DELAY + DIMMED_WAKE_EXTRA);
    cmd_o.far_time      = now_time_i + FAR_DELAY;
    case (act)
      ACT_TICK: cmd_o.kind = CMD_TICK;
      ACT_WAKE: cmd_o.kind = CMD_WAKE;
      ACT_KEY:  cmd_o.kind = CMD_KEY;
      ACT_NONE: cmd_o.kind = CMD_NOP;
      default:  cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lfss_back.sv
// Back end: holds the lighting state and carries out one command per cycle unless stalled.
`default_nettype none

module lfss_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lfss_pkg::cfg_t cfg_i,
  input  wire lfss_pkg::cmd_t cmd_i,
  input  wire logic          cmd_empty_i,
  output logic               cmd_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output lfss_pkg::res_t     res_o
);

  import lfss_pkg::*;

  logic [31:0] deadline_q, deadline_d;
  logic        active_q, active_d;
  logic        dimmed_q, dimmed_d;
  logic [7:0]  hue_q, hue_d;
  logic [7:0]  sat_q, sat_d;
  logic [7:0]  val_q, val_d;
  logic [7:0]  speed_q, speed_d;
  logic [7:0]  mode_q, mode_d;
  logic        on_q, on_d;

  logic        fire;
  logic        expired;
  logic [31:0] elapsed;
  logic [31:0] dl_add;
  logic        use_add;
  logic [7:0]  hue_up, hue_down;

  assign fire       = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  assign elapsed  = cmd_i.now_time - deadline_q;
  assign expired  = (elapsed < EXPIRE_LIMIT);
  assign hue_up   = cfg_i.target_hue - hue_q;
  assign hue_down = hue_q - cfg_i.target_hue;

  // Next state. Each expired-tick deadline change except the switch-off is
  // the old deadline plus one combined offset, so a single adder serves them.
  always_comb begin
    deadline_d = deadline_q;
    active_d   = active_q;
    dimmed_d   = dimmed_q;
    hue_d      = hue_q;
    sat_d      = sat_q;
    val_d      = val_q;
    speed_d    = speed_q;
    mode_d     = mode_q;
    on_d       = on_q;
    dl_add     = STEP_DELAY;
    use_add    = 1'b0;

    case (cmd_i.kind)
      CMD_WAKE: begin
        deadline_d = cmd_i.wake_time;
        active_d   = cfg_i.target_on;
      end
      CMD_KEY: begin
        deadline_d = dimmed_q ? cmd_i.wake_dim_time : cmd_i.wake_time;
        active_d   = cfg_i.target_on;
      end
      CMD_TICK: begin
        if (expired) begin
          use_add = 1'b1;
          if (active_q) begin
            on_d = 1'b1;
            if (speed_q != cfg_i.target_speed || mode_q != cfg_i.target_mode) begin
              // Fade out before switching the effect.
              if (val_q != 8'd0) begin
                val_d = val_q - 8'd1;
              end else begin
                sat_d   = 8'd0;
                speed_d = cfg_i.target_speed;
                mode_d  = cfg_i.target_mode;
              end
            end else if (val_q != cfg_i.target_val) begin
              val_d = (val_q < cfg_i.target_val) ? val_q + 8'd1 : val_q - 8'd1;
            end else if (hue_q != cfg_i.target_hue) begin
              // Hue turns the shorter way; a tie goes downwards.
              hue_d = (hue_up < hue_down) ? hue_q + 8'd1 : hue_q - 8'd1;
            end else if (sat_q != cfg_i.target_sat) begin
              sat_d = (sat_q < cfg_i.target_sat) ? sat_q + 8'd1 : sat_q - 8'd1;
            end else begin
              active_d = 1'b0;
              dimmed_d = 1'b0;
              dl_add   = STEP_DELAY + HOLD_DELAY;
            end
          end else if (!dimmed_q) begin
            if (cmd_i.palette) begin
              dl_add = STEP_DELAY + HOLD_DELAY;
            end else if (val_q > cfg_i.dim_floor) begin
              val_d  = val_q - 8'd1;
              dl_add = STEP_DELAY + DIM_STEP_EXTRA;
            end else begin
              dimmed_d = 1'b1;
              dl_add   = cfg_i.off_wait_step;
            end
          end else begin
            // Final fade: saturation first, then value, then switch off.
            if (sat_q != 8'd0) begin
              sat_d = sat_q - 8'd1;
            end else if (val_q != 8'd0) begin
              val_d = val_q - 8'd1;
            end else begin
              use_add  = 1'b0;
              deadline_d = cmd_i.far_time;
              dimmed_d = 1'b0;
              mode_d   = 8'd0;
              on_d     = 1'b0;
            end
          end
          if (use_add) begin
            deadline_d = deadline_q + dl_add;
          end
        end
      end
      CMD_NOP: begin
        deadline_d = deadline_q;
      end
      default: begin
        deadline_d = deadline_q;
      end
    endcase
  end

  // State registers, updated only when a command is carried out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= FAR_DELAY;
      active_q   <= 1'b0;
      dimmed_q   <= 1'b0;
      hue_q      <= 8'd0;
      sat_q      <= 8'd0;
      val_q      <= 8'd0;
      speed_q    <= 8'd0;
      mode_q     <= 8'd0;
      on_q       <= 1'b0;
    end else if (fire) begin
      deadline_q <= deadline_d;
      active_q   <= active_d;
      dimmed_q   <= dimmed_d;
      hue_q      <= hue_d;
      sat_q      <= sat_d;
      val_q      <= val_d;
      speed_q    <= speed_d;
      mode_q     <= mode_d;
      on_q       <= on_d;
    end
  end

  // The result word is the state after the step.
  always_comb begin
    res_o.hue   = hue_d;
    res_o.sat   = sat_d;
    res_o.val   = val_d;
    res_o.speed = speed_d;
    res_o.mode  = mode_d;
    res_o.on    = on_d;
  end

endmodule

`default_nettype wire
